/* hdl/mrp_pkg.sv */
// ----------------------------------------------------------------------------
// Management request parser package
// Shared codes, limits and the alter command argument count table.
// ----------------------------------------------------------------------------
package mrp_pkg;

  localparam logic [7:0] MAX_ARGS        = 8'd5;
  localparam logic [7:0] GET_CMD_COUNT   = 8'd6;
  localparam logic [7:0] ALTER_CMD_COUNT = 8'd4;

  localparam logic [1:0] REQ_GET   = 2'd0;
  localparam logic [1:0] REQ_ALTER = 2'd1;
  localparam logic [1:0] REQ_BARE  = 2'd2;

  localparam logic [2:0] STS_NONE      = 3'd0;
  localparam logic [2:0] STS_OK        = 3'd1;
  localparam logic [2:0] STS_BAD_TYPE  = 3'd2;
  localparam logic [2:0] STS_BAD_CMD   = 3'd3;
  localparam logic [2:0] STS_BAD_ARG   = 3'd4;

  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_TYPE      = 3'd1;
  localparam logic [2:0] CAUSE_CMD       = 3'd2;
  localparam logic [2:0] CAUSE_ARG_COUNT = 3'd3;
  localparam logic [2:0] CAUSE_ARG_LEN   = 3'd4;

  localparam logic [7:0] MAX_ARG_LEN_RESET = 8'd255;

  function automatic logic [2:0] alter_arg_count(input logic [1:0] cmd);
    logic [2:0] n;
    case (cmd)
      2'd0:    n = 3'd5;
      2'd1:    n = 3'd2;
      2'd2:    n = 3'd1;
      2'd3:    n = 3'd1;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

/* hdl/mgmt_request_parser.sv */
// ----------------------------------------------------------------------------
// Management request parser
// Byte-at-a-time parser for get, alter and bare management requests,
// reporting argument payload bytes with slot and offset.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-------------------------------
//  input     | in        | in_valid / in_stall | action, data_byte
//  result    | out       | out_valid/out_stall | phase .. arg_end (10 fields)
//  config    | in        | cfg_write           | cfg_data (max_arg_len)
//
//  One item per cycle unless the input stalls; each result appears in the cycle after its item.
//  Parser state and the result register are updated in a single clocked pass.
//  Input stalls only while a result is held and its consumer stalls.
//  rst (synchronous) returns the parser to the type phase, max_arg_len to 255.
// ----------------------------------------------------------------------------
module mgmt_request_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] phase,
  output logic [1:0] request_kind,
  output logic [2:0] command_index,
  output logic [2:0] resp_code,
  output logic [2:0] fault_code,
  output logic       arg_valid,
  output logic [2:0] arg_slot,
  output logic [7:0] arg_offset,
  output logic [7:0] arg_data,
  output logic       arg_end
);
  import mrp_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_COUNT = 3'd2,
    PH_ARGS  = 3'd3,
    PH_DONE  = 3'd4,
    PH_TRAP  = 3'd5
  } phase_t;

  phase_t     parse_phase, parse_phase_next;
  logic [1:0] kind_reg, kind_reg_next;
  logic [2:0] command_reg, command_reg_next;
  logic [2:0] expected_args, expected_args_next;
  logic [2:0] args_left, args_left_next;
  logic [7:0] current_len, current_len_next;
  logic [7:0] bytes_read, bytes_read_next;
  logic [2:0] status_reg, status_reg_next;
  logic [2:0] cause_reg, cause_reg_next;
  logic [7:0] max_arg_len;

  logic       a_valid, a_end;
  logic [2:0] a_slot;
  logic [7:0] a_off, a_data;
  logic [7:0] bytes_inc;
  logic       accept;

  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign bytes_inc = bytes_read + 8'd1;

  always_comb begin
    parse_phase_next   = parse_phase;
    kind_reg_next      = kind_reg;
    command_reg_next   = command_reg;
    expected_args_next = expected_args;
    args_left_next     = args_left;
    current_len_next   = current_len;
    bytes_read_next    = bytes_read;
    status_reg_next    = status_reg;
    cause_reg_next     = cause_reg;
    a_valid = 1'b0;
    a_end   = 1'b0;
    a_slot  = 3'd0;
    a_off   = 8'd0;
    a_data  = 8'd0;
    if (action) begin
      parse_phase_next   = PH_TYPE;
      kind_reg_next      = REQ_GET;
      command_reg_next   = 3'd0;
      expected_args_next = 3'd0;
      args_left_next     = 3'd0;
      current_len_next   = 8'd0;
      bytes_read_next    = 8'd0;
      status_reg_next    = STS_NONE;
      cause_reg_next     = CAUSE_NONE;
    end else begin
      case (parse_phase)
        PH_TYPE: begin
          if (data_byte <= {6'd0, REQ_BARE}) begin
            kind_reg_next = data_byte[1:0];
            if (data_byte[1:0] == REQ_BARE) begin
              status_reg_next  = STS_OK;
              parse_phase_next = PH_DONE;
            end else begin
              parse_phase_next = PH_CMD;
            end
          end else begin
            status_reg_next  = STS_BAD_TYPE;
            cause_reg_next   = CAUSE_TYPE;
            parse_phase_next = PH_TRAP;
          end
        end
        PH_CMD: begin
          if (kind_reg == REQ_GET && data_byte < GET_CMD_COUNT) begin
            command_reg_next = data_byte[2:0];
            status_reg_next  = STS_OK;
            parse_phase_next = PH_DONE;
          end else if (kind_reg == REQ_ALTER && data_byte < ALTER_CMD_COUNT) begin
            command_reg_next   = data_byte[2:0];
            expected_args_next = alter_arg_count(data_byte[1:0]);
            parse_phase_next   = PH_COUNT;
          end else begin
            status_reg_next  = STS_BAD_CMD;
            cause_reg_next   = CAUSE_CMD;
            parse_phase_next = PH_TRAP;
          end
        end
        PH_COUNT: begin
          if (data_byte != 8'd0 && data_byte == {5'd0, expected_args} &&
              data_byte <= MAX_ARGS) begin
            args_left_next   = data_byte[2:0];
            bytes_read_next  = 8'd0;
            current_len_next = 8'd0;
            parse_phase_next = PH_ARGS;
          end else begin
            status_reg_next  = STS_BAD_ARG;
            cause_reg_next   = CAUSE_ARG_COUNT;
            parse_phase_next = PH_TRAP;
          end
        end
        PH_ARGS: begin
          if (current_len == bytes_read) begin
            // length byte of the next argument
            bytes_read_next  = 8'd0;
            current_len_next = data_byte;
            if (data_byte == 8'd0) begin
              status_reg_next  = STS_BAD_ARG;
              cause_reg_next   = CAUSE_ARG_COUNT;
              parse_phase_next = PH_TRAP;
            end
          end else if (bytes_read < max_arg_len) begin
            a_valid         = 1'b1;
            a_slot          = expected_args - args_left;
            a_off           = bytes_read;
            a_data          = data_byte;
            bytes_read_next = bytes_inc;
            if (bytes_inc == current_len) begin
              a_end          = 1'b1;
              args_left_next = args_left - 3'd1;
              if (args_left == 3'd1) begin
                status_reg_next  = STS_OK;
                parse_phase_next = PH_DONE;
              end
            end
          end else begin
            status_reg_next  = STS_BAD_ARG;
            cause_reg_next   = CAUSE_ARG_LEN;
            parse_phase_next = PH_TRAP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_TYPE;
      kind_reg      <= REQ_GET;
      command_reg   <= 3'd0;
      expected_args <= 3'd0;
      args_left     <= 3'd0;
      current_len   <= 8'd0;
      bytes_read    <= 8'd0;
      status_reg    <= STS_NONE;
      cause_reg     <= CAUSE_NONE;
      max_arg_len   <= MAX_ARG_LEN_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_arg_len <= cfg_data;
      end
      if (accept) begin
        parse_phase   <= parse_phase_next;
        kind_reg      <= kind_reg_next;
        command_reg   <= command_reg_next;
        expected_args <= expected_args_next;
        args_left     <= args_left_next;
        current_len   <= current_len_next;
        bytes_read    <= bytes_read_next;
        status_reg    <= status_reg_next;
        cause_reg     <= cause_reg_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      phase         <= parse_phase_next;
      request_kind  <= kind_reg_next;
      command_index <= command_reg_next;
      resp_code     <= status_reg_next;
      fault_code    <= cause_reg_next;
      arg_valid     <= a_valid;
      arg_slot      <= a_slot;
      arg_offset    <= a_off;
      arg_data      <= a_data;
      arg_end       <= a_end;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && arg_valid) |-> (phase == PH_ARGS || phase == PH_DONE))
    else $error("payload byte reported outside argument phase");

  a_end_is_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && arg_end) |-> arg_valid)
    else $error("argument end without payload byte");

  a_cause_on_trap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((fault_code != CAUSE_NONE) == (phase == PH_TRAP)))
    else $error("trap cause disagrees with phase");
`endif

endmodule
